// ===== sv/bss_pkg.sv =====
// shared types and codes for the bounded sequence store
package bss_pkg;

  // operation codes carried in the mode field
  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_READ_POS   = 3'd3,
    MODE_KEEP_FIRST = 3'd4,
    MODE_DROP_FIRST = 3'd5
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] value;
    logic [7:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    status_t     status;
    logic [7:0]  length;
    logic        empty_flag;
  } out_item_t;

endpackage

// ===== sv/bounded_sequence_store_top.sv =====
// bounded double-ended sequence kept in a ring ram with start pointer and count
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in_     | input     | in_valid/in_stall  | mode, value, position
//  out_    | output    | out_valid/out_stall| read_data, status, length, empty_flag
//
// one item is accepted per cycle while in_stall is low; its result passes
// through the ram read port, then the output register
// start pointer and count update at the accepting edge, so the next item
// sees them at once; ram write-then-read at back-to-back items needs no bypass
// reset clears pointer, count and valid flags; ram contents are not cleared
// a middle stage holds one item while the output register waits, so in_stall
// rises only when both hold items and out_stall is high
module bounded_sequence_store_top #(
  parameter int DEPTH      = 128,
  parameter int ELEM_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bss_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output bss_pkg::out_item_t out_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // ring index width
  localparam int CW = $clog2(DEPTH + 1);                // count width
  localparam int NW = (CW > 8) ? CW : 8;                // compare width
  localparam int SW = CW + 1;                           // ring sum width

  // result fields waiting on the ram read
  typedef struct packed {
    bss_pkg::status_t status;
    logic [7:0]       length;
    logic             empty_flag;
    logic             is_read;
  } mid_info_t;

  // ring state
  logic [AW-1:0] start_r, start_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // pipeline
  logic               mid_valid_r;
  mid_info_t          mid_r, mid_nxt;
  logic               out_valid_r;
  bss_pkg::out_item_t out_item_r;

  logic in_acc;
  logic mid_adv;

  // ram ports
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [ELEM_WIDTH-1:0] ram_wdata, ram_rdata;

  logic [NW-1:0] n_ext, cnt_ext;
  logic [CW-1:0] n_cnt;
  logic          full;

  // start + offset wrapped into the ring; correct only for offsets up to DEPTH
  function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] start,
                                               input logic [CW-1:0] offset);
    logic [SW-1:0] sum;
    sum = SW'(start) + SW'(offset);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // handshake: middle stage moves on whenever the output register frees up
  assign mid_adv  = !out_valid_r || !out_stall;
  assign in_stall = mid_valid_r && !mid_adv;
  assign in_acc   = in_valid && !in_stall;

  assign n_ext   = NW'(in_item.position);
  assign cnt_ext = NW'(count_r);
  assign n_cnt   = n_ext[CW-1:0];
  assign full    = (count_r == CW'(DEPTH));

  assign ram_wdata = ELEM_WIDTH'(in_item.value);

  // operation decode
  always_comb begin
    logic [NW-1:0] len_ext;
    start_nxt        = start_r;
    count_nxt        = count_r;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_waddr        = ring_slot(start_r, count_r);
    ram_raddr        = ring_slot(start_r, n_cnt);
    mid_nxt.status   = bss_pkg::ST_OK;
    mid_nxt.is_read  = 1'b0;
    unique case (in_item.mode)
      bss_pkg::MODE_PUSH_FRONT: begin
        if (full) begin
          mid_nxt.status = bss_pkg::ST_FULL;
        end else begin
          start_nxt = (start_r == '0) ? AW'(DEPTH - 1) : start_r - 1'b1;
          ram_waddr = start_nxt;
          ram_we    = in_acc;
          count_nxt = count_r + 1'b1;
        end
      end
      bss_pkg::MODE_PUSH_BACK: begin
        if (full) begin
          mid_nxt.status = bss_pkg::ST_FULL;
        end else begin
          ram_we    = in_acc;
          count_nxt = count_r + 1'b1;
        end
      end
      bss_pkg::MODE_POP_FRONT: begin
        if (count_r == '0) begin
          mid_nxt.status = bss_pkg::ST_EMPTY;
        end else begin
          start_nxt = (start_r == AW'(DEPTH - 1)) ? '0 : start_r + 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      bss_pkg::MODE_READ_POS: begin
        if (n_ext >= cnt_ext) begin
          mid_nxt.status = bss_pkg::ST_RANGE;
        end else begin
          ram_re          = in_acc;
          mid_nxt.is_read = 1'b1;
        end
      end
      bss_pkg::MODE_KEEP_FIRST: begin
        if (n_ext > cnt_ext) begin
          mid_nxt.status = bss_pkg::ST_RANGE;
        end else begin
          count_nxt = n_cnt;
        end
      end
      bss_pkg::MODE_DROP_FIRST: begin
        if (n_ext > cnt_ext) begin
          mid_nxt.status = bss_pkg::ST_RANGE;
        end else begin
          // dropping everything of a full ring leaves start where it was
          start_nxt = ring_slot(start_r, n_cnt);
          count_nxt = count_r - n_cnt;
        end
      end
      default: begin
        // unused modes: no change, status ok
      end
    endcase
    len_ext            = NW'(count_nxt);
    mid_nxt.length     = len_ext[7:0];
    mid_nxt.empty_flag = (count_nxt == '0);
  end

  // ring state and middle stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= '0;
      count_r     <= '0;
      mid_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        start_r <= start_nxt;
        count_r <= count_nxt;
      end
      if (in_acc) begin
        mid_valid_r <= 1'b1;
      end else if (mid_adv) begin
        mid_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mid_r <= mid_nxt;
    end
  end

  // output register; ram data is held until the next read, which only
  // issues when the middle stage is empty or moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mid_adv) begin
      out_valid_r <= mid_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_adv && mid_valid_r) begin
      out_item_r.read_data  <= mid_r.is_read ? 32'(ram_rdata) : '0;
      out_item_r.status     <= mid_r.status;
      out_item_r.length     <= mid_r.length;
      out_item_r.empty_flag <= mid_r.empty_flag;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  bss_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // count never passes the ring size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count above ring size");

  // one ram access per item
  a_ram_single: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("ram read and write in the same cycle");

  // a full pipe with a stalled output must stall the input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("input not stalled with both stages held");

  // failed requests never carry read data
  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.status != bss_pkg::ST_OK) |-> out_item_r.read_data == '0)
    else $error("read data on a failed request");

endmodule

// ===== sv/bss_ram.sv =====
// generic single-write, single-read ram with registered read data
module bss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for the bounded sequence store: mirrored ring, random traffic
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH          = 128;
  localparam int LONG_HOLD      = 200;   // cycles of the long receiver hold-off
  localparam int WATCHDOG_LIMIT = 3000;  // cycles without any handshake
  localparam int TAIL_CYCLES    = 8;     // tail cycles after the last phase
  localparam int SHOW_LIMIT     = 10;

  // mode codes the block treats as no-ops
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  logic               clk   = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  bss_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  bss_pkg::out_item_t out_item;

  always #5 clk = ~clk;

  bounded_sequence_store_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // ---------------------------------------------------------------------------
  // mirror of the ring: contents, head slot and element count
  // ---------------------------------------------------------------------------
  logic [31:0] mirror_ram [DEPTH];
  logic [6:0]  mirror_head  = '0;
  logic [7:0]  mirror_count = '0;

  bss_pkg::in_item_t  seq_op_queue[$];     // operations waiting to be offered
  bss_pkg::out_item_t seq_reply_queue[$];  // replies the block still owes, oldest first

  int plan_len      = 0;  // length the queued operations will leave behind
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_asks     = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  int ops_taken     = 0;
  int replies_seen  = 0;
  int bad_results   = 0;
  int peak_len      = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  // applies one operation to the mirror and returns the reply it must give
  function automatic bss_pkg::out_item_t seq_apply(input bss_pkg::in_item_t op);
    bss_pkg::out_item_t res;
    logic [6:0]         slot;
    res = '0;
    res.status = bss_pkg::ST_OK;
    case (op.mode)
      bss_pkg::MODE_PUSH_FRONT: begin
        if (mirror_count == DEPTH) begin
          res.status = bss_pkg::ST_FULL;
        end else begin
          mirror_head = mirror_head - 7'd1;
          mirror_ram[mirror_head] = op.value;
          mirror_count = mirror_count + 8'd1;
        end
      end
      bss_pkg::MODE_PUSH_BACK: begin
        if (mirror_count == DEPTH) begin
          res.status = bss_pkg::ST_FULL;
        end else begin
          slot = mirror_head + mirror_count[6:0];
          mirror_ram[slot] = op.value;
          mirror_count = mirror_count + 8'd1;
        end
      end
      bss_pkg::MODE_POP_FRONT: begin
        if (mirror_count == 0) begin
          res.status = bss_pkg::ST_EMPTY;
        end else begin
          mirror_head = mirror_head + 7'd1;
          mirror_count = mirror_count - 8'd1;
        end
      end
      bss_pkg::MODE_READ_POS: begin
        if (op.position >= mirror_count) begin
          res.status = bss_pkg::ST_RANGE;
        end else begin
          slot = mirror_head + op.position[6:0];
          res.read_data = mirror_ram[slot];
        end
      end
      bss_pkg::MODE_KEEP_FIRST: begin
        if (op.position > mirror_count) begin
          res.status = bss_pkg::ST_RANGE;
        end else begin
          mirror_count = op.position;
        end
      end
      bss_pkg::MODE_DROP_FIRST: begin
        if (op.position > mirror_count) begin
          res.status = bss_pkg::ST_RANGE;
        end else begin
          // dropping all 128 wraps the head back onto itself
          mirror_head = mirror_head + op.position[6:0];
          mirror_count = mirror_count - op.position;
        end
      end
      default: ;
    endcase
    res.length     = mirror_count;
    res.empty_flag = (mirror_count == 0);
    status_seen[res.status]++;
    if (mirror_count > peak_len) peak_len = mirror_count;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building: queue an operation and track the length it leads to
  // ---------------------------------------------------------------------------
  task automatic add_op(input logic [2:0] mode, input logic [31:0] value,
                        input logic [7:0] position);
    bss_pkg::in_item_t op;
    op.mode     = mode;
    op.value    = value;
    op.position = position;
    seq_op_queue.push_back(op);
    case (mode)
      bss_pkg::MODE_PUSH_FRONT, bss_pkg::MODE_PUSH_BACK: if (plan_len < DEPTH) plan_len++;
      bss_pkg::MODE_POP_FRONT:  if (plan_len > 0) plan_len--;
      bss_pkg::MODE_KEEP_FIRST: if (position <= plan_len) plan_len = position;
      bss_pkg::MODE_DROP_FIRST: if (position <= plan_len) plan_len -= position;
      default: ;
    endcase
  endtask

  // mostly sensible traffic around the current length, with some noise,
  // occasional runs up to full and occasional complete drains
  task automatic queue_random_ops(input int how_many);
    int added;
    int pick;
    int span;
    int pos;
    added = 0;
    while (added < how_many) begin
      pick = $urandom_range(99);
      span = (plan_len < 6) ? plan_len : 6;
      if (pick < 4) begin
        // anything goes, spare modes and wild positions included
        add_op(3'($urandom_range(7)), $urandom, 8'($urandom_range(255)));
        added++;
      end else if (pick == 4) begin
        // fill up, then push against the full store from both ends
        while (plan_len < DEPTH) begin
          add_op($urandom_range(1) ? bss_pkg::MODE_PUSH_BACK : bss_pkg::MODE_PUSH_FRONT,
                 $urandom, 8'($urandom));
          added++;
        end
        add_op(bss_pkg::MODE_PUSH_FRONT, $urandom, 8'($urandom));
        add_op(bss_pkg::MODE_PUSH_BACK, $urandom, 8'($urandom));
        added += 2;
      end else if (pick == 5) begin
        // drop everything, then poke the empty store
        add_op(bss_pkg::MODE_DROP_FIRST, $urandom, 8'(plan_len));
        add_op(bss_pkg::MODE_POP_FRONT, $urandom, 8'($urandom));
        add_op(bss_pkg::MODE_READ_POS, $urandom, 8'd0);
        added += 3;
      end else if (pick < 46) begin
        add_op($urandom_range(1) ? bss_pkg::MODE_PUSH_BACK : bss_pkg::MODE_PUSH_FRONT,
               $urandom, 8'($urandom));
        added++;
      end else if (pick < 58) begin
        add_op(bss_pkg::MODE_POP_FRONT, $urandom, 8'($urandom));
        added++;
      end else if (pick < 78) begin
        if (plan_len > 0 && $urandom_range(99) < 85) begin
          pos = $urandom_range(plan_len - 1);
        end else if ($urandom_range(1) == 1) begin
          pos = plan_len + $urandom_range(2);
        end else begin
          pos = $urandom_range(255);
        end
        add_op(bss_pkg::MODE_READ_POS, $urandom, 8'(pos));
        added++;
      end else if (pick < 89) begin
        if ($urandom_range(99) < 85) pos = plan_len - $urandom_range(span);
        else pos = plan_len + 1 + $urandom_range(126);
        add_op(bss_pkg::MODE_KEEP_FIRST, $urandom, 8'(pos));
        added++;
      end else begin
        if ($urandom_range(99) < 85) pos = $urandom_range(span);
        else pos = plan_len + 1 + $urandom_range(126);
        add_op(bss_pkg::MODE_DROP_FIRST, $urandom, 8'(pos));
        added++;
      end
    end
  endtask

  // sender pauses until every owed reply has come back; returns at a falling edge
  task automatic wait_drained();
    while (seq_op_queue.size() != 0 || in_valid || seq_reply_queue.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int hold_pct, input int how_many);
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    queue_random_ops(how_many);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued items, keeps a stalled item steady, and feeds the
  // mirror with every item the block takes
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        seq_reply_queue.push_back(seq_apply(in_item));
        ops_taken++;
      end
      // only move on once the current item is gone (or there was none)
      if (!in_valid || !in_stall) begin
        if (seq_op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item  <= seq_op_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each reply against the oldest owed one and drives stall,
  // including the long hold-off that backs the block up
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : reply_check
    bss_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (seq_reply_queue.size() == 0) begin
          bad_results++;
          if (bad_results <= SHOW_LIMIT)
            $display("%0t: reply with nothing owed: data %h status %0d len %0d empty %b",
                     $realtime, out_item.read_data, out_item.status, out_item.length,
                     out_item.empty_flag);
        end else begin
          want = seq_reply_queue.pop_front();
          if (out_item.read_data !== want.read_data || out_item.status !== want.status ||
              out_item.length !== want.length ||
              out_item.empty_flag !== want.empty_flag) begin
            bad_results++;
            if (bad_results <= SHOW_LIMIT)
              $display({"%0t: reply %0d: want data %h st %0d len %0d empty %b, ",
                        "got data %h st %0d len %0d empty %b"},
                       $realtime, replies_seen, want.read_data, want.status, want.length,
                       want.empty_flag, out_item.read_data, out_item.status,
                       out_item.length, out_item.empty_flag);
          end
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (holds_done != hold_asks) begin
        out_stall  <= 1'b1;
        hold_left  <= LONG_HOLD - 1;
        holds_done <= holds_done + 1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog: too long without a single handshake on either side ends the run
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: everything against the empty store first
    add_op(bss_pkg::MODE_READ_POS, 32'h0, 8'd0);    // read on empty is out of range
    add_op(bss_pkg::MODE_POP_FRONT, 32'h0, 8'd0);   // pop on empty
    add_op(bss_pkg::MODE_KEEP_FIRST, 32'h0, 8'd0);  // keep n equal to length
    add_op(bss_pkg::MODE_DROP_FIRST, 32'h0, 8'd0);  // remove n equal to length
    add_op(bss_pkg::MODE_KEEP_FIRST, 32'h0, 8'd1);  // keep too many
    add_op(bss_pkg::MODE_DROP_FIRST, 32'h0, 8'd1);  // remove too many
    add_op(MODE_SPARE_A, 32'hFFFF_FFFF, 8'hFF);     // spare modes do nothing
    add_op(MODE_SPARE_B, 32'hFFFF_FFFF, 8'hFF);
    // a short sequence with extreme values at both ends
    add_op(bss_pkg::MODE_PUSH_BACK, 32'h0000_0000, 8'd0);
    add_op(bss_pkg::MODE_PUSH_FRONT, 32'hFFFF_FFFF, 8'hFF);
    add_op(bss_pkg::MODE_PUSH_BACK, 32'hA5A5_A5A5, 8'd0);
    add_op(bss_pkg::MODE_READ_POS, 32'h0, 8'd0);
    add_op(bss_pkg::MODE_READ_POS, 32'h0, 8'd2);
    add_op(bss_pkg::MODE_READ_POS, 32'h0, 8'd3);    // one past the end
    add_op(bss_pkg::MODE_READ_POS, 32'h0, 8'd255);
    add_op(bss_pkg::MODE_READ_POS, 32'h0, 8'd128);
    add_op(bss_pkg::MODE_KEEP_FIRST, 32'h0, 8'd2);
    add_op(bss_pkg::MODE_DROP_FIRST, 32'h0, 8'd1);  // rest keeps its order
    add_op(bss_pkg::MODE_READ_POS, 32'h0, 8'd0);
    add_op(bss_pkg::MODE_POP_FRONT, 32'h0, 8'd0);
    // fill from both ends so the head wraps, then work at capacity
    for (int k = 0; k < DEPTH; k++)
      add_op(k[0] ? bss_pkg::MODE_PUSH_BACK : bss_pkg::MODE_PUSH_FRONT, $urandom, 8'd0);
    add_op(bss_pkg::MODE_PUSH_BACK, 32'h1234_5678, 8'd0);  // push when full
    add_op(bss_pkg::MODE_PUSH_FRONT, 32'h1234_5678, 8'd0);
    add_op(bss_pkg::MODE_READ_POS, 32'h0, 8'd127);
    add_op(bss_pkg::MODE_READ_POS, 32'h0, 8'd128);
    add_op(bss_pkg::MODE_KEEP_FIRST, 32'h0, 8'd128);
    add_op(bss_pkg::MODE_DROP_FIRST, 32'h0, 8'd128);       // empties the full store
    wait_drained();

    // random traffic under each idling pattern
    run_phase(0, 0, 400);
    run_phase(74, 0, 400);
    run_phase(0, 74, 400);
    run_phase(27, 27, 400);

    // back-pressure: the receiver holds off while the sender keeps offering
    hold_asks++;
    run_phase(0, 0, 400);

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d operations: %0d ok, %0d full, %0d empty, %0d out of range",
             ops_taken, status_seen[bss_pkg::ST_OK], status_seen[bss_pkg::ST_FULL],
             status_seen[bss_pkg::ST_EMPTY], status_seen[bss_pkg::ST_RANGE]);
    $display("peak length %0d, %0d replies checked, %0d bad",
             peak_len, replies_seen, bad_results);
    if (bad_results == 0 && seq_reply_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bss_pkg.sv
sv/bss_ram.sv
sv/bounded_sequence_store_top.sv
test/tb_top.sv
